### design/skf_pkg.sv
package skf_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int COV_FRAC_BITS = 24;

  localparam int GAIN_W  = COV_FRAC_BITS + 1;
  localparam int TGT_W   = SAMPLE_BITS + 16;
  localparam int DIFF_W  = ((TGT_W > 32) ? TGT_W : 32) + 1;
  localparam int EXT_W   = DIFF_W + 1;

  localparam int PIECE_W     = 16;
  localparam int MAG_PIECES  = (DIFF_W + PIECE_W - 1) / PIECE_W;
  localparam int MAG_W       = MAG_PIECES * PIECE_W;
  localparam int PRED_PIECES = 32 / PIECE_W;
  localparam int ACC_W       = GAIN_W + MAG_W;
  localparam int PCNT_W      = $clog2(MAG_PIECES);
  localparam int DIV_CNT_W   = $clog2(GAIN_W + 1);
  localparam int REM_W       = 34;

  localparam logic [GAIN_W-1:0] ONE_F = GAIN_W'(64'd1 << COV_FRAC_BITS);

  localparam logic [31:0] Q_RESET   = 32'((64'd1 << COV_FRAC_BITS) / 64'd1000);
  localparam logic [31:0] R_RESET   = 32'(((64'd1 << COV_FRAC_BITS) * 64'd543) / 64'd1000);
  localparam logic [31:0] COV_RESET = 32'(((64'd1 << COV_FRAC_BITS) * 64'd2) / 64'd100);

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_PROC_NOISE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  typedef struct packed {
    logic en;
    logic first;
  } mac_ctrl_t;

endpackage

### design/skf_div.sv
module skf_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [31:0]                num_i,
  input  logic [32:0]                den_i,
  output logic [skf_pkg::GAIN_W-1:0] quot_o,
  output skf_pkg::div_status_t       status_o
);
  import skf_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [32:0]          den_q, den_d;
  logic [GAIN_W-1:0]    quo_q, quo_d;
  logic                 zero_q, zero_d;
  logic                 ge;
  logic [REM_W-1:0]     rem_sub;

  // restoring division, one quotient bit per cycle, msb first
  assign ge      = rem_q >= {1'b0, den_q};
  assign rem_sub = ge ? (rem_q - {1'b0, den_q}) : rem_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    zero_d = zero_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(GAIN_W);
      rem_d  = {2'b00, num_i};
      den_d  = den_i;
      quo_d  = '0;
      zero_d = (den_i == 33'd0);
    end else if (busy_q) begin
      rem_d = {rem_sub[REM_W-2:0], 1'b0};
      quo_d = {quo_q[GAIN_W-2:0], ge};
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quo_q  <= quo_d;
    zero_q <= zero_d;
  end

  // zero denominator means unit gain
  assign quot_o        = zero_q ? ONE_F : quo_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

### design/skf_mac.sv
module skf_mac (
  input  logic                        clk_i,
  input  skf_pkg::mac_ctrl_t          ctrl_i,
  input  logic [skf_pkg::GAIN_W-1:0]  a_i,
  input  logic [skf_pkg::PIECE_W-1:0] b_i,
  output logic [skf_pkg::ACC_W-1:0]   acc_o
);
  import skf_pkg::*;

  logic [GAIN_W+PIECE_W-1:0] prod;
  logic [ACC_W-1:0]          acc_q, acc_d;

  // pieces arrive most significant first
  assign prod = a_i * b_i;

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.en) begin
      acc_d = (ctrl_i.first ? '0 : (acc_q << PIECE_W)) + ACC_W'(prod);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

### design/scalar_kalman_filter_top.sv
// channel  direction  beat payload          handshake
// in       input      sample_i              in_valid_i / in_stall_o
// out      output     filtered_o, gain_o    out_valid_o / out_stall_i
// cfg      input      cfg_idx_i, cfg_data_i cfg_we_i (no wait)
//
// in_stall_o stays high while a beat is processed; covariance is Q8.24
// the gain divider makes one quotient bit per cycle, F+1 bits
// then 3 + 2 passes through the shared 25x16 multiplier for update and covariance
// a result waits in the output register; a new beat is taken while it waits
// async active-low reset loads default noise values, zero estimate, 0.02 covariance
module scalar_kalman_filter_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [skf_pkg::SAMPLE_BITS-1:0] sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [31:0]                   filtered_o,
  output logic [skf_pkg::GAIN_W-1:0]    gain_o,
  input  logic                          cfg_we_i,
  input  logic [skf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                   cfg_data_i
);
  import skf_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_PREP = 7'b0000010,
    S_DIV  = 7'b0000100,
    S_MSTP = 7'b0001000,
    S_STEP = 7'b0010000,
    S_MCOV = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [31:0]             q_q, r_q;
  logic [31:0]             est_q, cov_q;
  logic [SAMPLE_BITS-1:0]  sample_q;
  logic [31:0]             pred_q;
  logic                    neg_q;
  logic [DIFF_W-1:0]       mag_q;
  logic [GAIN_W-1:0]       gain_q;
  logic [MAG_W-1:0]        sr_q;
  logic [PCNT_W-1:0]       pcnt_q;
  logic [31:0]             est_new_q;
  logic                    out_valid_q;
  logic [31:0]             filtered_q;
  logic [GAIN_W-1:0]       gain_out_q;

  logic [32:0]             pred_sum;
  logic [31:0]             pred_sat;
  logic [32:0]             denom;
  logic [TGT_W-1:0]        tgt;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]       mag;
  logic [ACC_W-1:0]        acc;
  logic [ACC_W-1:0]        acc_rnd;
  logic [DIFF_W-1:0]       step;
  logic signed [EXT_W-1:0] est_ext, step_ext, est_next;
  logic [31:0]             est_sat;
  logic                    out_free;
  logic                    div_start;
  logic [GAIN_W-1:0]       div_quot;
  div_status_t             div_st;
  mac_ctrl_t               mac_ctrl;
  logic [GAIN_W-1:0]       mac_a;

  assign pred_sum = {1'b0, cov_q} + {1'b0, q_q};
  assign pred_sat = pred_sum[32] ? 32'hFFFF_FFFF : pred_sum[31:0];
  assign denom    = {1'b0, pred_q} + {1'b0, r_q};

  assign tgt  = {sample_q, 16'h0000};
  assign diff = $signed({{(DIFF_W-TGT_W){tgt[TGT_W-1]}}, tgt})
              - $signed({{(DIFF_W-32){est_q[31]}}, est_q});
  assign mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

  // negative error rounds the magnitude up so the estimate rounds down
  assign acc_rnd  = acc + (neg_q ? ACC_W'((64'd1 << COV_FRAC_BITS) - 64'd1) : '0);
  assign step     = acc_rnd[COV_FRAC_BITS +: DIFF_W];
  assign est_ext  = $signed({{(EXT_W-32){est_q[31]}}, est_q});
  assign step_ext = $signed({1'b0, step});
  assign est_next = neg_q ? (est_ext - step_ext) : (est_ext + step_ext);

  always_comb begin
    if (est_next > $signed({{(EXT_W-32){1'b0}}, 32'h7FFF_FFFF})) begin
      est_sat = 32'h7FFF_FFFF;
    end else if (est_next < $signed({{(EXT_W-32){1'b1}}, 32'h8000_0000})) begin
      est_sat = 32'h8000_0000;
    end else begin
      est_sat = est_next[31:0];
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d        = state_q;
    div_start      = 1'b0;
    mac_ctrl.en    = 1'b0;
    mac_ctrl.first = 1'b0;
    mac_a          = gain_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_PREP;
      end
      S_PREP: begin
        div_start = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        if (div_st.done) state_d = S_MSTP;
      end
      S_MSTP: begin
        mac_ctrl.en    = 1'b1;
        mac_ctrl.first = (pcnt_q == PCNT_W'(MAG_PIECES - 1));
        if (pcnt_q == '0) state_d = S_STEP;
      end
      S_STEP: begin
        state_d = S_MCOV;
      end
      S_MCOV: begin
        mac_a          = ONE_F - gain_q;
        mac_ctrl.en    = 1'b1;
        mac_ctrl.first = (pcnt_q == PCNT_W'(PRED_PIECES - 1));
        if (pcnt_q == '0) state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  skf_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (pred_q),
    .den_i    (denom),
    .quot_o   (div_quot),
    .status_o (div_st)
  );

  skf_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .a_i    (mac_a),
    .b_i    (sr_q[MAG_W-1 -: PIECE_W]),
    .acc_o  (acc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      q_q         <= Q_RESET;
      r_q         <= R_RESET;
      est_q       <= '0;
      cov_q       <= COV_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_PROC_NOISE: q_q <= cfg_data_i;
          REG_MEAS_NOISE: r_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == S_FIN && out_free) begin
        out_valid_q <= 1'b1;
        est_q       <= est_new_q;
        cov_q       <= acc[COV_FRAC_BITS +: 32];
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      sample_q <= sample_i;
      pred_q   <= pred_sat;
    end
    if (state_q == S_PREP) begin
      neg_q <= diff[DIFF_W-1];
      mag_q <= mag;
    end
    if (state_q == S_DIV && div_st.done) begin
      gain_q <= div_quot;
      sr_q   <= {{(MAG_W-DIFF_W){1'b0}}, mag_q};
      pcnt_q <= PCNT_W'(MAG_PIECES - 1);
    end
    if (state_q == S_MSTP || state_q == S_MCOV) begin
      sr_q   <= sr_q << PIECE_W;
      pcnt_q <= pcnt_q - PCNT_W'(1);
    end
    if (state_q == S_STEP) begin
      est_new_q <= est_sat;
      sr_q      <= {pred_q, {(MAG_W-32){1'b0}}};
      pcnt_q    <= PCNT_W'(PRED_PIECES - 1);
    end
    if (state_q == S_FIN && out_free) begin
      filtered_q <= est_new_q;
      gain_out_q <= gain_q;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign filtered_o  = filtered_q;
  assign gain_o      = gain_out_q;

`ifndef SYNTHESIS
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_st.busy || div_st.done) |-> state_q == S_DIV)
    else $error("divider active outside the divide phase");

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN))
    else $error("result beat raised without finishing an item");

  a_gain_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> gain_out_q <= ONE_F)
    else $error("gain above unity");

  a_fin_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && out_free) |=> (out_valid_q && state_q == S_IDLE))
    else $error("finished item not handed to output");

  a_est_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_FIN) |=> $stable(est_q))
    else $error("estimate changed outside the finish step");
`endif

endmodule

### tb/sv/skf_checker.sv
module skf_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic [skf_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic [31:0]                     filtered_i,
  input  logic [skf_pkg::GAIN_W-1:0]      gain_i,
  input  logic                            cfg_we_i,
  input  logic [skf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [31:0]                     cfg_data_i,
  output int                              fail_cnt_o,
  output int                              pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import skf_pkg::*;

  localparam longint unsigned UNITY     = 64'd1 << COV_FRAC_BITS;
  localparam longint unsigned FRAC_MASK = UNITY - 64'd1;
  localparam logic [31:0] Q_DEFAULT   = 32'd16777;
  localparam logic [31:0] R_DEFAULT   = 32'd9110028;
  localparam logic [31:0] COV_DEFAULT = 32'd335544;

  typedef struct packed {
    logic [31:0]       filtered;
    logic [GAIN_W-1:0] gain;
  } kf_result_t;

  kf_result_t         expected_updates[$];
  kf_result_t         oldest;
  logic [31:0]        proc_noise;
  logic [31:0]        meas_noise;
  logic [31:0]        covariance;
  logic signed [31:0] estimate;
  int                 beat_cnt;

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (fail_cnt_o < 50)
      $display("mismatch at result beat %0d, %s: got %h, expected %h",
               beat_cnt, what, got, want);
    fail_cnt_o++;
  endtask

  // one filter step on the local state, returns the expected result
  function automatic kf_result_t advance_filter(input logic [SAMPLE_BITS-1:0] smp);
    longint unsigned pred;
    longint unsigned denom;
    longint unsigned g;
    longint unsigned mag;
    longint unsigned prod;
    longint unsigned stp;
    longint signed   target;
    longint signed   diff;
    longint signed   nxt;
    kf_result_t      res;
    pred = 64'(covariance) + 64'(proc_noise);
    if (pred > 64'hFFFF_FFFF) pred = 64'hFFFF_FFFF;
    denom = pred + 64'(meas_noise);
    g = (denom == 64'd0) ? UNITY : (pred << COV_FRAC_BITS) / denom;
    target = longint'($signed(smp)) * 64'sd65536;
    diff = target - longint'(estimate);
    mag = (diff >= 0) ? diff : -diff;
    prod = g * (mag & FRAC_MASK);
    stp = g * (mag >> COV_FRAC_BITS) + (prod >> COV_FRAC_BITS);
    // negative corrections round toward minus infinity
    if (diff < 0 && (prod & FRAC_MASK) != 64'd0) stp = stp + 64'd1;
    if (diff >= 0) begin
      nxt = longint'(estimate) + $signed(stp);
    end else begin
      nxt = longint'(estimate) - $signed(stp);
    end
    if (nxt > 64'sd2147483647) nxt = 64'sd2147483647;
    if (nxt < -64'sd2147483648) nxt = -64'sd2147483648;
    estimate = nxt[31:0];
    covariance = 32'(((UNITY - g) * pred) >> COV_FRAC_BITS);
    res.filtered = estimate;
    res.gain = g[GAIN_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proc_noise = Q_DEFAULT;
      meas_noise = R_DEFAULT;
      covariance = COV_DEFAULT;
      estimate = '0;
      beat_cnt = 0;
      expected_updates.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_updates.size() == 0) begin
          flag_mismatch("result with nothing expected", filtered_i, '0);
        end else begin
          oldest = expected_updates.pop_front();
          if (filtered_i !== oldest.filtered)
            flag_mismatch("filtered", filtered_i, oldest.filtered);
          if (gain_i !== oldest.gain)
            flag_mismatch("gain", 32'(gain_i), 32'(oldest.gain));
        end
        beat_cnt++;
      end
      if (in_valid_i && !in_stall_i) expected_updates.push_back(advance_filter(sample_i));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PROC_NOISE: proc_noise = cfg_data_i;
          REG_MEAS_NOISE: meas_noise = cfg_data_i;
          default: ;
        endcase
      end
    end
    pending_o = expected_updates.size();
  end

endmodule

### tb/sv/scalar_kalman_filter_top_tb.sv
module scalar_kalman_filter_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import skf_pkg::*;

  localparam int HOLD_CYCLES = 600;

  logic                   clk_i = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [SAMPLE_BITS-1:0] sample = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [31:0]            filtered;
  logic [GAIN_W-1:0]      gain;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx = '0;
  logic [31:0]            cfg_data = '0;
  int                     fail_cnt;
  int                     pending_cnt;

  bit                     tx_idle_en = 1'b0;
  bit                     rx_idle_en = 1'b0;
  bit                     hold_req = 1'b0;
  logic [SAMPLE_BITS-1:0] level = '0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  scalar_kalman_filter_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .sample_i    (sample),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .filtered_o  (filtered),
    .gain_o      (gain),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  skf_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .sample_i    (sample),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .filtered_i  (filtered),
    .gain_i      (gain),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending_cnt)
  );

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      case ($urandom_range(0, 3))
        0: return 16'h7FFF;
        1: return 16'h8000;
        2: return 16'h0000;
        default: return 16'hFFFF;
      endcase
    end
    // steady signal plus a little noise, lets the filter settle
    if (r < 45) return level + SAMPLE_BITS'($urandom_range(0, 64)) - SAMPLE_BITS'(32);
    return SAMPLE_BITS'($urandom);
  endfunction

  function automatic logic [31:0] pick_noise();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 32'h0010_0000);
      3: return $urandom;
      4: return 32'h0100_0000;
      default: return $urandom_range(1000, 32'h0200_0000);
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp);
    int gap;
    gap = tx_idle_en ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    sample <= smp;
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
  endtask

  // receiver side stall generator
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        if (stall_left > 0) begin
          stall_left--;
        end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                   : $urandom_range(1, 3);
        end
        out_stall <= (stall_left > 0);
      end
    end
  end

  initial begin
    int n_items;
    int mode;
    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // reset noise settings: extremes and rounding of negative corrections
    send_sample(16'h0000);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h0001);
    send_sample(16'hFFFF);
    send_sample(16'h5555);
    send_sample(16'hAAAA);
    drain();

    // no noise at all: unit gain, then covariance hits zero and the denominator too
    write_reg(REG_PROC_NOISE, 32'h0000_0000);
    write_reg(REG_MEAS_NOISE, 32'h0000_0000);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h0064);
    send_sample(16'hFF9C);
    drain();

    // full-scale noise: predicted covariance saturates
    write_reg(REG_PROC_NOISE, 32'hFFFF_FFFF);
    write_reg(REG_MEAS_NOISE, 32'hFFFF_FFFF);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'h3039);
    drain();

    // no process noise: gain shrinks as the covariance falls
    write_reg(REG_PROC_NOISE, 32'h0000_0000);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      write_reg(REG_PROC_NOISE, pick_noise());
      write_reg(REG_MEAS_NOISE, pick_noise());
      mode = ph % 4;
      tx_idle_en = (mode == 1 || mode == 3);
      rx_idle_en = (mode == 2 || mode == 3);
      level = SAMPLE_BITS'($urandom);
      n_items = $urandom_range(160, 220);
      if (ph == 4) begin
        // long receiver hold while input keeps coming
        tx_idle_en = 1'b0;
        hold_req = 1'b1;
      end
      for (int k = 0; k < n_items; k++) begin
        if ($urandom_range(0, 49) == 0) level = SAMPLE_BITS'($urandom);
        send_sample(pick_sample());
      end
      drain();
    end

    repeat (50) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("FAIL");
    $finish;
  end

endmodule
